// File: src/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// shared types, codes and sizes for the aging priority queue
// ----------------------------------------------------------------------------
package apq_pkg;

  // slot store geometry
  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // field widths
  localparam int OP_W    = 2;
  localparam int ID_W    = 16;
  localparam int PRI_W   = 8;
  localparam int TIME_W  = 32;
  localparam int ORD_W   = 32;
  localparam int STAT_W  = 3;
  localparam int OCC_W   = 7;
  localparam int CAP_W   = 7;
  localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W   = PRI_W + TIME_W + ORD_W;

  // configuration port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_AGE  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_PUSHED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_POPPED = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
  localparam logic [STAT_W-1:0] ST_AGED   = 3'd4;

  // register indexes (byte address / 4)
  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [CAP_W-1:0]  CAPACITY_RST  = 7'd64;
  localparam logic [TIME_W-1:0] THRESHOLD_RST = 32'd10000;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   task_id;
    logic [PRI_W-1:0]  task_priority;
    logic [TIME_W-1:0] time_now;
  } apq_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [PRI_W-1:0]  out_priority;
    logic [OCC_W-1:0]  occupancy;
  } apq_out_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] arrival;
    logic [ORD_W-1:0]  order;
  } apq_entry_t;

  localparam int ENTRY_W = $bits(apq_entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_FINISH
  } apq_state_t;

endpackage

// File: src/apq_ram.sv
// ----------------------------------------------------------------------------
// apq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module apq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/aging_priority_queue.sv
// ----------------------------------------------------------------------------
// aging_priority_queue
// bounded priority queue of task entries with push, pop and aging
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high, and the receiver
// cannot stall it, so capture it when done is seen. Every operation returns
// one result with the occupancy after the operation. A rejected push, a pop
// or age on an empty queue and the unused operation code answer in the cycle
// after the transfer. A push walks the valid bits from slot 0 to the first
// free slot. Pop and age run one pass over all 64 slots through the single
// read port of the slot ram; pop compares each slot in the one compare unit.
// A new command may be started in the cycle that done is high. The user must
// write configuration through the apb port only while the block is idle; the
// block itself does not enforce this. Registers sit at byte address 0
// (capacity limit) and 4 (aging threshold).
// ----------------------------------------------------------------------------
module aging_priority_queue
  import apq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              start,
  output logic              busy,
  input  apq_in_t           request,
  // result channel
  output logic              done,
  output apq_out_t          result,
  // apb configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  apq_state_t        state, state_next;
  apq_in_t           req;             // command held for the whole operation
  logic [CNT_W-1:0]  cnt;             // slot walk / read issue counter
  logic              pipe_vld;        // ram read data valid this cycle
  logic [IDX_W-1:0]  pipe_idx;        // slot that the read data belongs to
  logic              found;
  logic [KEY_W-1:0]  best_key;        // {priority, arrival, insertion number}
  logic [ID_W-1:0]   best_id;
  logic [IDX_W-1:0]  best_idx;
  logic [DEPTH-1:0]  slot_valid;
  logic [CNT_W-1:0]  entry_count;
  logic [ORD_W-1:0]  insert_counter;
  logic [CAP_W-1:0]  capacity_limit;
  logic [TIME_W-1:0] aging_threshold;

  // --------------------------------------------------------------------------
  // control from the sequencer
  // --------------------------------------------------------------------------
  logic              accept;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  apq_entry_t        ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  apq_entry_t        ram_rdata;
  logic              cnt_inc;
  logic              take_best;
  logic              set_valid;
  logic              clr_valid;
  logic              count_inc;
  logic              count_dec;
  logic              load_result;
  apq_out_t          result_next;

  // --------------------------------------------------------------------------
  // shared datapath terms
  // --------------------------------------------------------------------------
  logic [LIM_W-1:0]  limit;
  logic [LIM_W-1:0]  count_ext;
  logic              has_room;
  logic              is_empty;
  logic [IDX_W-1:0]  walk_idx;
  logic              scan_end;
  logic [KEY_W-1:0]  rd_key;
  logic              rd_wins;
  logic [TIME_W-1:0] elapsed;
  logic              rd_ages;
  logic              cfg_write;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign pready    = 1'b1;

  // limit in force is min(capacity_limit, DEPTH)
  assign limit     = (LIM_W'(capacity_limit) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH)
                                                              : LIM_W'(capacity_limit);
  assign count_ext = LIM_W'(entry_count);
  assign has_room  = (count_ext < limit);
  assign is_empty  = (entry_count == '0);

  assign walk_idx  = cnt[IDX_W-1:0];
  assign scan_end  = (cnt == CNT_W'(DEPTH));

  // the one compare unit: lexicographic order on priority, arrival, insertion
  assign rd_key    = {ram_rdata.pri, ram_rdata.arrival, ram_rdata.order};
  assign rd_wins   = slot_valid[pipe_idx] && (!found || (rd_key < best_key));

  // aging test, wait taken modulo 2^32
  assign elapsed   = req.time_now - ram_rdata.arrival;
  assign rd_ages   = slot_valid[pipe_idx] && (ram_rdata.pri != '0) &&
                     (elapsed >= aging_threshold);

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.operation)
            OP_PUSH: if (has_room) state_next = S_PUSH;
            OP_POP,
            OP_AGE:  if (!is_empty) state_next = S_SCAN;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        if (!slot_valid[walk_idx]) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (scan_end) state_next = S_FINISH;
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = pipe_idx;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = walk_idx;
    cnt_inc     = 1'b0;
    take_best   = 1'b0;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    count_inc   = 1'b0;
    count_dec   = 1'b0;
    load_result = 1'b0;
    result_next = '{status: ST_AGED, out_id: '0, out_priority: '0,
                    occupancy: OCC_W'(count_ext)};
    unique case (state)
      S_IDLE: begin
        // answers decided at the transfer need no slot access
        if (accept) begin
          case (request.operation)
            OP_PUSH: begin
              if (!has_room) begin
                load_result        = 1'b1;
                result_next.status = ST_FULL;
              end
            end
            OP_POP: begin
              if (is_empty) begin
                load_result        = 1'b1;
                result_next.status = ST_EMPTY;
              end
            end
            OP_AGE: begin
              if (is_empty) load_result = 1'b1;
            end
            default: load_result = 1'b1;
          endcase
        end
      end
      S_PUSH: begin
        // walk valid bits to the lowest free slot
        if (!slot_valid[walk_idx]) begin
          ram_we                = 1'b1;
          ram_waddr             = walk_idx;
          ram_wdata.id          = req.task_id;
          ram_wdata.pri         = req.task_priority;
          ram_wdata.arrival     = req.time_now;
          ram_wdata.order       = insert_counter;
          set_valid             = 1'b1;
          count_inc             = 1'b1;
          load_result           = 1'b1;
          result_next.status    = ST_PUSHED;
          result_next.occupancy = OCC_W'(count_ext + LIM_W'(1));
        end else begin
          cnt_inc = 1'b1;
        end
      end
      S_SCAN: begin
        // issue one read a cycle, handle the slot read the cycle before
        if (!scan_end) begin
          ram_re  = 1'b1;
          cnt_inc = 1'b1;
        end
        if (pipe_vld) begin
          if (req.operation == OP_POP) begin
            take_best = rd_wins;
          end else if (rd_ages) begin
            ram_we        = 1'b1;
            ram_wdata.pri = ram_rdata.pri - PRI_W'(1);
          end
        end
      end
      S_FINISH: begin
        load_result = 1'b1;
        if (req.operation == OP_POP) begin
          clr_valid                = 1'b1;
          count_dec                = 1'b1;
          result_next.status       = ST_POPPED;
          result_next.out_id       = best_id;
          result_next.out_priority = best_key[KEY_W-1 -: PRI_W];
          result_next.occupancy    = OCC_W'(count_ext - LIM_W'(1));
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // slot ram: id, priority, arrival stamp, insertion number per slot
  // --------------------------------------------------------------------------
  apq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pipe_vld       <= 1'b0;
      found          <= 1'b0;
      slot_valid     <= '0;
      entry_count    <= '0;
      insert_counter <= '0;
      done           <= 1'b0;
    end else begin
      state    <= state_next;
      pipe_vld <= ram_re;
      done     <= load_result;
      if (accept) begin
        found <= 1'b0;
      end else if (take_best) begin
        found <= 1'b1;
      end
      if (set_valid) slot_valid[walk_idx] <= 1'b1;
      if (clr_valid) slot_valid[best_idx] <= 1'b0;
      if (count_inc) begin
        entry_count    <= entry_count + CNT_W'(1);
        insert_counter <= insert_counter + ORD_W'(1);
      end else if (count_dec) begin
        entry_count <= entry_count - CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
      cnt <= '0;
    end else if (cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end
    pipe_idx <= walk_idx;
    if (take_best) begin
      best_key <= rd_key;
      best_id  <= ram_rdata.id;
      best_idx <= pipe_idx;
    end
    if (load_result) result <= result_next;
  end

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit  <= CAPACITY_RST;
      aging_threshold <= THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_CAPACITY:  capacity_limit  <= pwdata[CAP_W-1:0];
        REG_THRESHOLD: aging_threshold <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CAPACITY:  prdata = APB_DW'(capacity_limit);
      REG_THRESHOLD: prdata = APB_DW'(aging_threshold);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: dv/tb_aging_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aging_priority_queue
// self-checking bench for the aging priority queue: commands go in through
// the start/busy handshake and every result strobed on done is compared
// field by field against a shadow queue kept inside the bench
// ----------------------------------------------------------------------------
module tb_aging_priority_queue;
  import apq_pkg::*;

  // op code three has no name in the package; the block treats it as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 1000000;
  // longest single command is a pop or age pass
  localparam int SETTLE_TICKS = 80;
  localparam int PHASE_ITEMS  = 530;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  apq_in_t           request = '0;
  logic              done;
  apq_out_t          result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  aging_priority_queue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // shadow queue: slot contents, counters and register copies
  // --------------------------------------------------------------------------
  logic              slot_used  [DEPTH];
  logic [ID_W-1:0]   slot_tag   [DEPTH];
  logic [PRI_W-1:0]  slot_level [DEPTH];
  logic [TIME_W-1:0] slot_stamp [DEPTH];
  logic [ORD_W-1:0]  slot_seq   [DEPTH];
  int                held_count = 0;
  logic [ORD_W-1:0]  next_seq = '0;
  logic [CAP_W-1:0]  cap_reg = CAPACITY_RST;
  logic [TIME_W-1:0] threshold_reg = THRESHOLD_RST;

  // results predicted at each command transfer, oldest first
  apq_out_t          awaited_results [$];

  int                error_count = 0;
  int                cycle_count = 0;
  int                status_seen [5] = '{default: 0};
  int                reg_writes = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  initial begin
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  end

  // pop order: lowest level, then earliest stamp, then earliest insertion
  function automatic logic leaves_first(int a, int b);
    if (slot_level[a] != slot_level[b]) return slot_level[a] < slot_level[b];
    if (slot_stamp[a] != slot_stamp[b]) return slot_stamp[a] < slot_stamp[b];
    return slot_seq[a] < slot_seq[b];
  endfunction

  // applies one command to the shadow queue and returns the expected result
  function automatic apq_out_t apply_queue_op(apq_in_t cmd);
    apq_out_t          r;
    int                limit;
    int                best;
    logic [TIME_W-1:0] waited;
    r = '0;
    r.status = ST_AGED;
    best = -1;
    // a limit register above the store size is clamped to the store size
    limit = (cap_reg < DEPTH) ? int'(cap_reg) : DEPTH;
    case (cmd.operation)
      OP_PUSH: begin
        r.status = ST_FULL;
        if (held_count < limit) begin
          // lowest free slot takes the entry
          for (int i = 0; i < DEPTH; i++) begin
            if (!slot_used[i]) begin
              slot_used[i]  = 1'b1;
              slot_tag[i]   = cmd.task_id;
              slot_level[i] = cmd.task_priority;
              slot_stamp[i] = cmd.time_now;
              slot_seq[i]   = next_seq;
              next_seq      = next_seq + 1'b1;
              held_count++;
              r.status = ST_PUSHED;
              break;
            end
          end
        end
      end
      OP_POP: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i] && (best < 0 || leaves_first(i, best))) best = i;
        end
        if (best >= 0) begin
          slot_used[best] = 1'b0;
          r.out_id        = slot_tag[best];
          r.out_priority  = slot_level[best];
          held_count--;
          r.status = ST_POPPED;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_AGE: begin
        // wait is a modulo-2^32 difference, arrival is never restamped
        for (int i = 0; i < DEPTH; i++) begin
          waited = cmd.time_now - slot_stamp[i];
          if (slot_used[i] && slot_level[i] != 0 && waited >= threshold_reg)
            slot_level[i] = slot_level[i] - 1'b1;
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every done strobe must match the oldest prediction
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    apq_out_t want;
    apq_out_t got;
    if (!rst && done === 1'b1) begin
      got = result;
      if (awaited_results.size() == 0) begin
        report_mismatch("unrequested result", '0, 32'(got));
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.out_id !== want.out_id)
          report_mismatch("out_id", 32'(want.out_id), 32'(got.out_id));
        if (got.out_priority !== want.out_priority)
          report_mismatch("out_priority", 32'(want.out_priority), 32'(got.out_priority));
        if (got.occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(want.occupancy), 32'(got.occupancy));
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("tb_aging_priority_queue: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers: everything changes on the falling edge
  // --------------------------------------------------------------------------

  // one command transfer, optionally preceded by a sender gap; start is left
  // high after the transfer so back-to-back commands need no extra edge
  task automatic send_command(apq_in_t cmd, int gap);
    apq_out_t predicted;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    request <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    // transfer taken at this edge
    predicted = apply_queue_op(cmd);
    awaited_results = {awaited_results, predicted};
    status_seen[predicted.status]++;
  endtask

  // stop sending and let every awaited result come back
  task automatic wait_until_idle();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, done when pready is seen
  task automatic write_register(logic idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_CAPACITY) cap_reg = value[CAP_W-1:0];
    else                     threshold_reg = value;
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic apq_in_t make_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                       logic [PRI_W-1:0] pri, logic [TIME_W-1:0] t);
    apq_in_t c;
    c.operation     = op;
    c.task_id       = id;
    c.task_priority = pri;
    c.time_now      = t;
    return c;
  endfunction

  // random command around a running millisecond clock; small priorities
  // dominate so that ties on level and stamp show up often
  function automatic apq_in_t random_command(int push_pct, int step_max);
    apq_in_t c;
    int      roll;
    c.task_id       = ID_W'($urandom);
    c.task_priority = ($urandom_range(0, 9) < 7) ? PRI_W'($urandom_range(0, 7))
                                                 : PRI_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      c.operation = OP_PUSH;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60)      c.operation = OP_POP;
      else if (roll < 92) c.operation = OP_AGE;
      else                c.operation = OP_UNUSED;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      // stray timestamp, the running clock is left alone
      c.time_now = $urandom;
    end else begin
      if (roll >= 15) clock_ms = clock_ms + $urandom_range(1, step_max);
      c.time_now = clock_ms;
    end
    return c;
  endfunction

  // mostly short gaps, sometimes long ones that cover the whole scan
  function automatic int sender_gap(int idle_pct);
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 80);
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // empty queue cases, field extremes, tie rules and threshold extremes
  task automatic test_directed();
    // empty pop, age on empty, unused op code, all with reset registers
    send_command(make_cmd(OP_POP,    16'h0000, 8'h00, 32'd0), 0);
    send_command(make_cmd(OP_AGE,    16'hFFFF, 8'hFF, 32'hFFFF_FFFF), 0);
    send_command(make_cmd(OP_UNUSED, 16'hA5A5, 8'h5A, 32'h5A5A_A5A5), 0);
    // extremes, then equal levels with equal and with earlier stamps
    send_command(make_cmd(OP_PUSH, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF), 0);
    send_command(make_cmd(OP_PUSH, 16'h0000, 8'h00, 32'd0), 0);
    send_command(make_cmd(OP_PUSH, 16'h1234, 8'd5, 32'd100), 0);
    send_command(make_cmd(OP_PUSH, 16'h1235, 8'd5, 32'd100), 0);
    send_command(make_cmd(OP_PUSH, 16'h1236, 8'd5, 32'd50), 0);
    // reset threshold of 10000 promotes the stamp-50 entry and the wrapped one
    send_command(make_cmd(OP_AGE, 16'h0000, 8'h00, 32'd10050), 0);
    send_command(make_cmd(OP_POP, 16'h0000, 8'h00, 32'd10051), 0);
    send_command(make_cmd(OP_POP, 16'h0000, 8'h00, 32'd10052), 0);
    // zero threshold: every nonzero level drops
    wait_until_idle();
    write_register(REG_THRESHOLD, 32'd0);
    send_command(make_cmd(OP_AGE, 16'h0000, 8'h00, 32'd0), 0);
    // full-scale threshold: only a wait of 2^32-1 qualifies
    wait_until_idle();
    write_register(REG_THRESHOLD, 32'hFFFF_FFFF);
    send_command(make_cmd(OP_PUSH, 16'hBEEF, 8'd9, 32'd500), 0);
    send_command(make_cmd(OP_AGE,  16'h0000, 8'h00, 32'd499), 0);
    send_command(make_cmd(OP_AGE,  16'h0000, 8'h00, 32'd498), 0);
    // drain everything and pop twice more on empty
    repeat (6) send_command(make_cmd(OP_POP, 16'h0000, 8'h00, 32'd600), 0);
    wait_until_idle();
  endtask

  // limit register at zero, one and above the store size
  task automatic test_capacity();
    write_register(REG_CAPACITY, 32'd0);
    repeat (2) send_command(random_command(100, 10), 0);
    send_command(make_cmd(OP_POP, 16'h0000, 8'h00, clock_ms), 0);
    wait_until_idle();
    write_register(REG_CAPACITY, 32'd1);
    repeat (2) send_command(random_command(100, 10), 0);
    repeat (2) send_command(make_cmd(OP_POP, 16'h0000, 8'h00, clock_ms), 0);
    wait_until_idle();
    // 127 clamps to the store size: fill past it, then empty it
    write_register(REG_CAPACITY, 32'd127);
    repeat (DEPTH + 2) send_command(random_command(100, 10), sender_gap(20));
    repeat (DEPTH + 1) send_command(make_cmd(OP_POP, 16'h0000, 8'h00, clock_ms),
                                    sender_gap(20));
    wait_until_idle();
  endtask

  // bursts that alternately fill and drain the queue, with a pause halfway
  // where the sender holds off until every result is back
  task automatic test_random_phase(int idle_pct, logic [CAP_W-1:0] cap,
                                   logic [TIME_W-1:0] thr, logic [TIME_W-1:0] t0,
                                   int step_max);
    int push_pct;
    wait_until_idle();
    write_register(REG_CAPACITY, 32'(cap));
    write_register(REG_THRESHOLD, thr);
    clock_ms = t0;
    push_pct = 65;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 40 == 0) push_pct = (push_pct == 65) ? 30 : 65;
      if (n == PHASE_ITEMS / 2) wait_until_idle();
      send_command(random_command(push_pct, step_max), sender_gap(idle_pct));
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_capacity();
    // sender idles often, then mostly, then never
    test_random_phase(20, 7'd8,   32'd25,    32'd1000,        20);
    test_random_phase(67, 7'd100, 32'd200,   32'hFFFF_F000,   20);
    test_random_phase(0,  7'd33,  32'd10000, 32'h7FFF_0000,   500);

    wait_until_idle();
    $display("covered: %0d pushed, %0d rejected full, %0d popped, %0d empty pops, %0d age/no-op",
             status_seen[ST_PUSHED], status_seen[ST_FULL], status_seen[ST_POPPED],
             status_seen[ST_EMPTY], status_seen[ST_AGED]);
    $display("limits 0/1/8/33/100/127, thresholds 0 to 2^32-1, time wrap, %0d register writes",
             reg_writes);
    if (error_count == 0) begin
      $display("tb_aging_priority_queue: PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_aging_priority_queue: FAIL");
    end
    $finish;
  end

endmodule
